// File: design/tmnp_pkg.sv
// ----------------------------------------------------------------------------
// tmnp_pkg
// Types, codes and sizes shared by the token mutex node blocks.
// ----------------------------------------------------------------------------
package tmnp_pkg;

  localparam int NODES_DEF = 16;
  localparam int ID_W      = 4;
  localparam int COUNT_W   = 5;
  localparam int HINT_W    = 5;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [HINT_W-1:0]  NO_NODE       = HINT_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_RST     = COUNT_W'(16);
  localparam logic [ID_W-1:0]    SELF_RST      = '0;

  localparam logic CFG_SELF_ID    = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    OP_REQUEST_CS = 3'd0,
    OP_ENTER_CS   = 3'd1,
    OP_RELEASE_CS = 3'd2,
    OP_GOT_REQ    = 3'd3,
    OP_GOT_TOKEN  = 3'd4,
    OP_TIMEOUT    = 3'd5,
    OP_GOT_CONS   = 3'd6,
    OP_GOT_QUIET  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    M_REST       = 3'd0,
    M_WAITING    = 3'd1,
    M_ACTIVE     = 3'd2,
    M_CONSULTING = 3'd3,
    M_QUERY      = 3'd4,
    M_OBSERVER   = 3'd5,
    M_CANDIDATE  = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    K_REQUEST  = 3'd0,
    K_TOKEN    = 3'd1,
    K_CONSULT  = 3'd2,
    K_QUIET    = 3'd3,
    K_FAILURE  = 3'd4,
    K_ELECTION = 3'd5,
    K_ELECTED  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] peer;
  } in_t;

  typedef struct packed {
    logic [2:0]      msg_kind;
    logic [ID_W-1:0] dest;
    logic [ID_W-1:0] content;
    logic            last;
  } out_t;

  // One queued send job: a single message or a broadcast sweep.
  typedef struct packed {
    logic            bcast;
    kind_t           kind;
    logic [ID_W-1:0] dest;
    logic [ID_W-1:0] content;
  } cmd_t;

endpackage

// File: design/tmnp_front.sv
// ----------------------------------------------------------------------------
// tmnp_front
// Event decoder: updates the protocol state and queues the send job.
// ----------------------------------------------------------------------------
module tmnp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  tmnp_pkg::in_t           in_data,
  output logic                    in_ready,
  input  logic [tmnp_pkg::ID_W-1:0] self_id,
  output logic                    push_valid,
  output tmnp_pkg::cmd_t          push_cmd,
  input  logic                    push_ready
);

  tmnp_pkg::mode_t                mode_r, mode_nxt;
  logic [tmnp_pkg::HINT_W-1:0]    owner_r, owner_nxt;
  logic [tmnp_pkg::HINT_W-1:0]    waiter_r, waiter_nxt;
  logic                           wants_r, wants_nxt;
  logic                           emit;
  logic                           accept;
  logic [tmnp_pkg::HINT_W-1:0]    peer_w;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign peer_w   = {1'b0, in_data.peer};

  always_comb begin
    mode_nxt         = mode_r;
    owner_nxt        = owner_r;
    waiter_nxt       = waiter_r;
    wants_nxt        = wants_r;
    emit             = 1'b0;
    push_cmd.bcast   = 1'b0;
    push_cmd.kind    = tmnp_pkg::K_REQUEST;
    push_cmd.dest    = in_data.peer;
    push_cmd.content = self_id;
    case (tmnp_pkg::op_t'(in_data.op))
      tmnp_pkg::OP_REQUEST_CS: begin
        mode_nxt  = tmnp_pkg::M_WAITING;
        wants_nxt = 1'b1;
        if (owner_r != tmnp_pkg::NO_NODE) begin
          emit          = 1'b1;
          push_cmd.dest = owner_r[tmnp_pkg::ID_W-1:0];
          owner_nxt     = tmnp_pkg::NO_NODE;
        end
      end
      tmnp_pkg::OP_ENTER_CS: begin
        mode_nxt = tmnp_pkg::M_ACTIVE;
      end
      tmnp_pkg::OP_RELEASE_CS: begin
        wants_nxt = 1'b0;
        mode_nxt  = tmnp_pkg::M_REST;
        if (waiter_r != tmnp_pkg::NO_NODE) begin
          emit             = 1'b1;
          push_cmd.kind    = tmnp_pkg::K_TOKEN;
          push_cmd.dest    = waiter_r[tmnp_pkg::ID_W-1:0];
          push_cmd.content = waiter_r[tmnp_pkg::ID_W-1:0];
          waiter_nxt       = tmnp_pkg::NO_NODE;
        end
      end
      tmnp_pkg::OP_GOT_REQ: begin
        if (owner_r == tmnp_pkg::NO_NODE) begin
          if (wants_r) begin
            waiter_nxt = peer_w;
          end else begin
            emit          = 1'b1;
            push_cmd.kind = tmnp_pkg::K_TOKEN;
          end
        end else begin
          emit             = 1'b1;
          push_cmd.dest    = owner_r[tmnp_pkg::ID_W-1:0];
          push_cmd.content = in_data.peer;
        end
        owner_nxt = peer_w;
      end
      tmnp_pkg::OP_TIMEOUT: begin
        push_cmd.bcast = 1'b1;
        case (mode_r)
          tmnp_pkg::M_WAITING: begin
            emit          = 1'b1;
            push_cmd.kind = tmnp_pkg::K_CONSULT;
            mode_nxt      = tmnp_pkg::M_CONSULTING;
          end
          tmnp_pkg::M_CONSULTING: begin
            emit          = 1'b1;
            push_cmd.kind = tmnp_pkg::K_FAILURE;
            mode_nxt      = tmnp_pkg::M_QUERY;
          end
          tmnp_pkg::M_QUERY, tmnp_pkg::M_OBSERVER: begin
            emit          = 1'b1;
            push_cmd.kind = tmnp_pkg::K_ELECTION;
            mode_nxt      = tmnp_pkg::M_CANDIDATE;
          end
          tmnp_pkg::M_CANDIDATE: begin
            // Take the token; the hint is cleared, so a pending want sends nothing.
            emit          = 1'b1;
            push_cmd.kind = tmnp_pkg::K_ELECTED;
            owner_nxt     = tmnp_pkg::NO_NODE;
            waiter_nxt    = tmnp_pkg::NO_NODE;
            mode_nxt      = wants_r ? tmnp_pkg::M_WAITING : tmnp_pkg::M_REST;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      tmnp_pkg::OP_GOT_CONS: begin
        if (waiter_r == peer_w) begin
          emit          = 1'b1;
          push_cmd.kind = tmnp_pkg::K_QUIET;
        end
      end
      tmnp_pkg::OP_GOT_QUIET: begin
        if (mode_r == tmnp_pkg::M_CONSULTING) begin
          mode_nxt = tmnp_pkg::M_WAITING;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_valid = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= tmnp_pkg::M_REST;
      owner_r  <= tmnp_pkg::NO_NODE;
      waiter_r <= tmnp_pkg::NO_NODE;
      wants_r  <= 1'b0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      owner_r  <= owner_nxt;
      waiter_r <= waiter_nxt;
      wants_r  <= wants_nxt;
    end
  end

endmodule

// File: design/tmnp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tmnp_cmd_fifo
// Short job queue between the event decoder and the send sequencer.
// ----------------------------------------------------------------------------
module tmnp_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  tmnp_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           head_valid,
  output tmnp_pkg::cmd_t head_cmd,
  input  logic           pop
);

  tmnp_pkg::cmd_t                 mem_r [tmnp_pkg::QDEPTH];
  logic [tmnp_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [tmnp_pkg::QPTR_W:0]      cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = (cnt_r != (tmnp_pkg::QPTR_W+1)'(tmnp_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// File: design/tmnp_back.sv
// ----------------------------------------------------------------------------
// tmnp_back
// Send sequencer: expands jobs into words and holds the output register.
// ----------------------------------------------------------------------------
module tmnp_back #(
  parameter int NODES = tmnp_pkg::NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  tmnp_pkg::cmd_t               head_cmd,
  output logic                         pop,
  input  logic [tmnp_pkg::ID_W-1:0]    self_id,
  input  logic [tmnp_pkg::COUNT_W-1:0] node_count,
  output logic                         out_valid,
  output tmnp_pkg::out_t               out_data,
  input  logic                         out_ready
);

  localparam int CAP_I = (NODES < 16) ? NODES : 16;
  localparam logic [tmnp_pkg::COUNT_W-1:0] CAP = tmnp_pkg::COUNT_W'(CAP_I);

  logic [tmnp_pkg::COUNT_W-1:0] j_r, j_nxt;
  logic [tmnp_pkg::COUNT_W-1:0] cnt, self_w, cand, cand_p1;
  logic                         out_valid_r, out_valid_nxt;
  tmnp_pkg::out_t               out_r, out_nxt;
  logic                         slot_free, in_range, is_last;

  assign slot_free = !out_valid_r || out_ready;
  assign cnt       = (node_count > CAP) ? CAP : node_count;
  assign self_w    = {1'b0, self_id};
  // Step over this node's own id.
  assign cand      = (j_r == self_w) ? j_r + 1'b1 : j_r;
  assign cand_p1   = cand + 1'b1;
  assign in_range  = (cand < cnt);
  assign is_last   = (cand_p1 >= cnt) || ((cand_p1 == self_w) && (cand_p1 + 1'b1 >= cnt));

  always_comb begin
    pop           = 1'b0;
    j_nxt         = j_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (head_valid && slot_free) begin
      if (!head_cmd.bcast) begin
        pop              = 1'b1;
        out_valid_nxt    = 1'b1;
        out_nxt.msg_kind = head_cmd.kind;
        out_nxt.dest     = head_cmd.dest;
        out_nxt.content  = head_cmd.content;
        out_nxt.last     = 1'b1;
      end else if (!in_range) begin
        // Nothing left to send: drop the job.
        pop   = 1'b1;
        j_nxt = '0;
      end else begin
        out_valid_nxt    = 1'b1;
        out_nxt.msg_kind = head_cmd.kind;
        out_nxt.dest     = cand[tmnp_pkg::ID_W-1:0];
        out_nxt.content  = self_id;
        out_nxt.last     = is_last;
        if (is_last) begin
          pop   = 1'b1;
          j_nxt = '0;
        end else begin
          j_nxt = cand_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/token_mutex_node_protocol.sv
// ----------------------------------------------------------------------------
// token_mutex_node_protocol
// One node of a token-based mutual exclusion protocol with failure recovery.
// ----------------------------------------------------------------------------
// Path: an event is decoded and its job queued when it is accepted; the job's
//   first word then moves into the output register once the slot is free.
// Throughput: one event per cycle while the two-job queue has room; a broadcast
//   drains one word per ready cycle, one per other node below the count.
// Reset: synchronous, active low; clears mode, hints, flags and the queue,
//   sets self_id to 0 and node_count to 16. No clearing pass.
// ----------------------------------------------------------------------------
module token_mutex_node_protocol #(
  parameter int NODES = tmnp_pkg::NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // event channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tmnp_pkg::in_t                in_data,
  // message channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output tmnp_pkg::out_t               out_data,
  // configuration writes
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tmnp_pkg::COUNT_W-1:0] cfg_data
);

  logic [tmnp_pkg::ID_W-1:0]    self_id_r;
  logic [tmnp_pkg::COUNT_W-1:0] node_count_r;

  logic           push_valid, push_ready;
  tmnp_pkg::cmd_t push_cmd;
  logic           head_valid, pop;
  tmnp_pkg::cmd_t head_cmd;

  // Hold the configuration; write it only while the node is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r    <= tmnp_pkg::SELF_RST;
      node_count_r <= tmnp_pkg::COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tmnp_pkg::CFG_SELF_ID:    self_id_r    <= cfg_data[tmnp_pkg::ID_W-1:0];
        tmnp_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data;
        default:                  node_count_r <= node_count_r;
      endcase
    end
  end

  // Front: decode the event, update protocol state, queue at most one send job.
  tmnp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .self_id    (self_id_r),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Queue: decouple decoding from a long broadcast drain.
  tmnp_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // Back: expand each job into words, ascending ids, last on the final word.
  tmnp_back #(
    .NODES (NODES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .self_id    (self_id_r),
    .node_count (node_count_r),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule

// File: verif/tb_token_mutex_node_protocol.sv
// ----------------------------------------------------------------------------
// tb_token_mutex_node_protocol
// Self-checking bench for one token mutex protocol node. A behavioral
// predictor tracks the node's mode, hints and flags, expands every accepted
// event into the outgoing message words it must cause, and a checker compares
// each word leaving the block, in order, field by field. Directed tests cover
// the token hand-off, the failure recovery chain, the node count edges and
// one long receiver hold-off, then random protocol traffic runs under several
// configurations with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_token_mutex_node_protocol;
  timeunit 1ns;
  timeprecision 1ps;

  import tmnp_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int NODE_LIMIT     = NODES_DEF;
  localparam int SETTLE_CYCLES  = 6;     // pad for the queue and output register
  localparam int RX_HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word on either side

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_index = CFG_SELF_ID;
  logic [COUNT_W-1:0]   cfg_data  = '0;

  token_mutex_node_protocol #(.NODES(NODE_LIMIT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Predicted node state and configuration
  // --------------------------------------------------------------------------
  mode_t              node_mode   = M_REST;
  logic [HINT_W-1:0]  owner_guess = NO_NODE;
  logic [HINT_W-1:0]  waiter      = NO_NODE;
  logic               holds_token = 1'b0;
  logic               wants_entry = 1'b0;
  logic [ID_W-1:0]    my_id       = SELF_RST;
  logic [COUNT_W-1:0] peer_count  = COUNT_RST;

  out_t pending_msgs[$];   // message words still owed by the block
  int   err_count   = 0;
  int   events_sent = 0;
  logic tx_idle_on  = 1'b0;
  logic rx_idle_on  = 1'b0;
  logic rx_hold_req = 1'b0;
  int   quiet_cycles = 0;
  out_t owed;

  // Append one message word; the last flag is fixed up once the event is done.
  function automatic void queue_msg(input kind_t kind, input logic [ID_W-1:0] dest,
                                    input logic [ID_W-1:0] content);
    out_t m;
    m.msg_kind = kind;
    m.dest     = dest;
    m.content  = content;
    m.last     = 1'b0;
    pending_msgs.push_back(m);
  endfunction

  // Sweep every other node below the effective count, lowest id first.
  function automatic void queue_broadcast(input kind_t kind);
    int span;
    span = int'(peer_count);
    if (span > NODE_LIMIT) span = NODE_LIMIT;
    if (span > 16) span = 16;
    for (int j = 0; j < span; j++)
      if (j != int'(my_id)) queue_msg(kind, 4'(j), my_id);
  endfunction

  function automatic void ask_for_token();
    node_mode   = M_WAITING;
    wants_entry = 1'b1;
    if (owner_guess != NO_NODE) begin
      queue_msg(K_REQUEST, owner_guess[ID_W-1:0], my_id);
      owner_guess = NO_NODE;
    end
  endfunction

  function automatic void predict_node_event(input op_t op, input logic [ID_W-1:0] peer);
    int   base;
    out_t tail;
    base = pending_msgs.size();
    case (op)
      OP_REQUEST_CS: ask_for_token();
      OP_ENTER_CS:   node_mode = M_ACTIVE;
      OP_RELEASE_CS: begin
        wants_entry = 1'b0;
        if (waiter != NO_NODE) begin
          holds_token = 1'b0;
          queue_msg(K_TOKEN, waiter[ID_W-1:0], waiter[ID_W-1:0]);
          waiter = NO_NODE;
        end
        node_mode = M_REST;
      end
      OP_GOT_REQ: begin
        if (owner_guess == NO_NODE) begin
          if (wants_entry) begin
            waiter = {1'b0, peer};
          end else begin
            holds_token = 1'b0;
            queue_msg(K_TOKEN, peer, my_id);
          end
        end else begin
          queue_msg(K_REQUEST, owner_guess[ID_W-1:0], peer);
        end
        owner_guess = {1'b0, peer};
      end
      OP_GOT_TOKEN:  holds_token = 1'b1;
      OP_TIMEOUT: begin
        case (node_mode)
          M_WAITING: begin
            node_mode = M_CONSULTING;
            queue_broadcast(K_CONSULT);
          end
          M_CONSULTING: begin
            node_mode = M_QUERY;
            queue_broadcast(K_FAILURE);
          end
          M_QUERY, M_OBSERVER: begin
            node_mode = M_CANDIDATE;
            queue_broadcast(K_ELECTION);
          end
          M_CANDIDATE: begin
            holds_token = 1'b1;
            owner_guess = NO_NODE;
            waiter      = NO_NODE;
            queue_broadcast(K_ELECTED);
            if (wants_entry) ask_for_token();
            else node_mode = M_REST;
          end
          default: ;
        endcase
      end
      OP_GOT_CONS: if (waiter == {1'b0, peer}) queue_msg(K_QUIET, peer, my_id);
      OP_GOT_QUIET: if (node_mode == M_CONSULTING) node_mode = M_WAITING;
      default: ;
    endcase
    // mark the final word of this event
    if (pending_msgs.size() > base) begin
      tail      = pending_msgs.pop_back();
      tail.last = 1'b1;
      pending_msgs.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one event word, hold it until accepted, then predict
  // --------------------------------------------------------------------------
  task automatic send_event(input op_t op, input logic [ID_W-1:0] peer);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, peer};
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_node_event(op, peer);
    events_sent++;
  endtask

  // Drop valid, wait for every owed word, then let zero-word events settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; call only while idle.
  task automatic set_config(input logic [ID_W-1:0] self_val,
                            input logic [COUNT_W-1:0] count_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SELF_ID;
    cfg_data  <= {1'b0, self_val};
    @(posedge clk);
    cfg_index <= CFG_NODE_COUNT;
    cfg_data  <= count_val;
    my_id     = self_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    peer_count = count_val;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready bursts, or a long hold-off when asked
  // --------------------------------------------------------------------------
  initial begin
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted message word with the oldest one owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_msgs.size() == 0) begin
        $error("unexpected message word: kind %0d dest %0d content %0d last %0d",
               out_data.msg_kind, out_data.dest, out_data.content, out_data.last);
        err_count++;
      end else begin
        owed = pending_msgs.pop_front();
        if (out_data.msg_kind !== owed.msg_kind) begin
          $error("msg_kind mismatch: expected %0d, actual %0d",
                 owed.msg_kind, out_data.msg_kind);
          err_count++;
        end
        if (out_data.dest !== owed.dest) begin
          $error("dest mismatch: expected %0d, actual %0d", owed.dest, out_data.dest);
          err_count++;
        end
        if (out_data.content !== owed.content) begin
          $error("content mismatch: expected %0d, actual %0d",
                 owed.content, out_data.content);
          err_count++;
        end
        if (out_data.last !== owed.last) begin
          $error("last mismatch: expected %0d, actual %0d", owed.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_token_mutex_node_protocol failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Run on reset configuration: self 0, sixteen nodes.
  task automatic test_reset_defaults();
    send_event(OP_REQUEST_CS, 4'd0);   // no hint yet, nothing goes out
    send_event(OP_TIMEOUT, 4'd15);     // consult sweep to nodes 1..15
    wait_quiet();
  endtask

  // Root answering, path forwarding, waiter hand-off and the quiet reply.
  task automatic test_token_handoff();
    set_config(4'd3, 5'd16);
    send_event(OP_RELEASE_CS, 4'd0);   // clear the wish, no waiter
    send_event(OP_GOT_TOKEN, 4'd7);
    send_event(OP_GOT_REQ, 4'd5);      // root and idle: token leaves
    send_event(OP_REQUEST_CS, 4'd2);   // request goes to the new hint
    send_event(OP_GOT_REQ, 4'd9);      // root but wanting: 9 queues behind us
    send_event(OP_GOT_CONS, 4'd9);     // consult from the waiter: answer quiet
    send_event(OP_GOT_CONS, 4'd4);     // consult from a stranger: silent
    send_event(OP_ENTER_CS, 4'd1);
    send_event(OP_RELEASE_CS, 4'd8);   // token passes to the waiter
    send_event(OP_GOT_REQ, 4'd15);     // not root: forward to the hint
    send_event(OP_GOT_CONS, 4'd0);
    wait_quiet();
  endtask

  // Walk the timeout chain through consulting, query and candidate back to waiting.
  task automatic test_failure_recovery();
    send_event(OP_REQUEST_CS, 4'd6);
    send_event(OP_TIMEOUT, 4'd0);      // waiting -> consulting
    send_event(OP_GOT_QUIET, 4'd2);    // back to waiting
    send_event(OP_TIMEOUT, 4'd0);      // consult again
    send_event(OP_TIMEOUT, 4'd0);      // failure sweep
    send_event(OP_TIMEOUT, 4'd0);      // election sweep
    send_event(OP_TIMEOUT, 4'd0);      // elected, re-request with no hint
    send_event(OP_RELEASE_CS, 4'd0);
    send_event(OP_TIMEOUT, 4'd0);      // at rest: nothing
    wait_quiet();
  endtask

  // Broadcast sizes at the count extremes, with self inside and outside.
  task automatic test_node_count_edges();
    set_config(4'd15, 5'd0);
    send_event(OP_REQUEST_CS, 4'd1);
    send_event(OP_TIMEOUT, 4'd0);      // empty sweep
    wait_quiet();
    set_config(4'd5, 5'd1);
    send_event(OP_TIMEOUT, 4'd0);      // self outside count: one word to 0
    wait_quiet();
    set_config(4'd0, 5'd1);
    send_event(OP_TIMEOUT, 4'd0);      // only self below count: empty
    wait_quiet();
    set_config(4'd0, 5'd31);
    send_event(OP_TIMEOUT, 4'd0);      // count clamps to sixteen
    wait_quiet();
    set_config(4'd1, 5'd2);
    send_event(OP_TIMEOUT, 4'd0);      // smallest real ring
    wait_quiet();
  endtask

  // Hold the receiver while the sender keeps going so the input stalls.
  task automatic test_output_backpressure();
    set_config(4'd10, 5'd16);
    tx_idle_on  = 1'b0;
    send_event(OP_RELEASE_CS, 4'd0);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 12; i++)
      send_event(OP_GOT_REQ, 4'($urandom_range(0, 15)));
    send_event(OP_REQUEST_CS, 4'd0);
    send_event(OP_TIMEOUT, 4'd0);
    wait_quiet();
  endtask

  // Mostly well-formed protocol rounds with random content, some noise.
  task automatic run_random_events(input int count);
    int         stop_at;
    int         pick;
    logic [3:0] asker;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        send_event(OP_REQUEST_CS, 4'($urandom_range(0, 15)));
        repeat ($urandom_range(1, 4)) send_event(OP_TIMEOUT, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 1) == 1) send_event(OP_GOT_QUIET, 4'($urandom_range(0, 15)));
      end else if (pick < 7) begin
        asker = 4'($urandom_range(0, 15));
        send_event(OP_REQUEST_CS, 4'($urandom_range(0, 15)));
        send_event(OP_GOT_TOKEN, 4'($urandom_range(0, 15)));
        send_event(OP_GOT_REQ, asker);
        send_event(OP_GOT_CONS,
                   ($urandom_range(0, 1) == 1) ? asker : 4'($urandom_range(0, 15)));
        send_event(OP_ENTER_CS, 4'($urandom_range(0, 15)));
        send_event(OP_RELEASE_CS, 4'($urandom_range(0, 15)));
      end else begin
        send_event(op_t'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic test_random_traffic();
    // both sides stalling
    set_config(4'($urandom_range(0, 15)), 5'd16);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random_events(30);
    wait_quiet();
    // two-node count, sender steady
    set_config(4'd0, 5'd2);
    tx_idle_on = 1'b0;
    run_random_events(25);
    wait_quiet();
    // any count the register holds, receiver steady
    set_config(4'd15, 5'($urandom_range(0, 31)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    run_random_events(25);
    wait_quiet();
    // last stretch: no idling at all
    set_config(4'($urandom_range(0, 15)), 5'($urandom_range(2, 16)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random_events(30);
    wait_quiet();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_token_handoff();
    test_failure_recovery();
    test_node_count_edges();
    test_output_backpressure();
    test_random_traffic();
    wait_quiet();
    if (err_count == 0) begin
      $display("tb_token_mutex_node_protocol passed");
    end else begin
      $display("tb_token_mutex_node_protocol failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tmnp_pkg.sv
design/tmnp_front.sv
design/tmnp_cmd_fifo.sv
design/tmnp_back.sv
design/token_mutex_node_protocol.sv
verif/tb_token_mutex_node_protocol.sv
